// File: rtl/tmf_pkg.sv
// Shared types, constants and register codes of the thresholded 3x3 mean filter.
// No dependencies; every other file of the block refers to this package by scope.
package tmf_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int ROW_W     = 12;
  localparam int OUT_ROW_W = 11;
  localparam int SUM_W     = 12;
  localparam int THR_W     = 8;
  localparam int IDX_W     = 2;

  localparam int DEF_MAX_LINE = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int MIN_SIZE     = 3;

  localparam logic [CFG_W-1:0] RST_LINE_WIDTH   = 12'd720;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd576;
  localparam logic [THR_W-1:0] RST_THRESHOLD    = 8'd16;

  // Divide by nine as a multiply by round-up(2^16 / 9) and a shift.
  localparam int RECIP_9     = 7282;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + 13;

  // Window columns held in cells; the newest column comes straight from the stores and the new sample.
  localparam int NUM_CELLS = 2;

  localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEEP_THRESH  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PIXEL,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

endpackage

// File: rtl/tmf_line_ram.sv
// Line store: one write port and one read port with registered read data.
// Depends on tmf_pkg for the sample width.
module tmf_line_ram #(
  parameter int DEPTH = tmf_pkg::DEF_MAX_LINE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tmf_pkg::PIX_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tmf_pkg::PIX_W-1:0] rdata_o
);

  logic [tmf_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [tmf_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the read data while the consuming stage is stalled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tmf_col_cell.sv
// Window column cell: holds one 3-sample column and its registered sum.
// Depends on tmf_pkg for col_t and widths.
module tmf_col_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  tmf_pkg::col_t             col_i,
  output tmf_pkg::col_t             col_o,
  output logic [tmf_pkg::SUM_W-1:0] sum_o
);

  tmf_pkg::col_t             col_q;
  logic [tmf_pkg::SUM_W-1:0] sum_q, sum_d;

  assign sum_d = tmf_pkg::SUM_W'(col_i.top) + tmf_pkg::SUM_W'(col_i.mid)
               + tmf_pkg::SUM_W'(col_i.bot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sum_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
      sum_q <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

// File: rtl/thresholded_3x3_mean_filter.sv
// Top level of the thresholded 3x3 mean filter: counters, pipeline and output register.
// Depends on tmf_pkg, tmf_line_ram and tmf_col_cell.
//
// Filters one 8-bit plane streamed in raster order, one pixel per input beat, and takes a
// beat every clock cycle while the output side keeps up. Each result is the truncated mean
// of the 3x3 neighbourhood, or the centre pixel when the mean lies more than keep_threshold
// away from it; border pixels pass through unchanged. The result for pixel (r, c) leaves
// after pixel (r+1, c+1) has gone in and passed the pipeline (store read, window
// and sum, divide and select). After the last pixel of a plane, send line_width+1 flush
// beats (or further pixels, which are dropped) to drain the tail; the last result carries
// frame_end and the next beat starts a new plane. Both line stores start undefined and
// need no clearing pass: undefined entries read early feed only border results. Write the
// size and threshold registers only while the block is idle; widths clamp to [3, MAX_LINE]
// and heights to [3, 2048].
module thresholded_3x3_mean_filter #(
  parameter int MAX_LINE = tmf_pkg::DEF_MAX_LINE
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [tmf_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [tmf_pkg::CFG_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tmf_pkg::PIX_W-1:0] pixel_in_i,
  input  logic                      flush_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tmf_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      frame_end_o
);

  localparam int AW    = $clog2(MAX_LINE);
  localparam int CNT_W = AW + 1;
  localparam int PW    = tmf_pkg::PIX_W;
  localparam int SW    = tmf_pkg::SUM_W;
  localparam int RW    = tmf_pkg::ROW_W;
  localparam int ORW   = tmf_pkg::OUT_ROW_W;

  // ---------------------------------------------------------------- configuration
  logic [tmf_pkg::CFG_W-1:0] line_width_q, frame_height_q;
  logic [tmf_pkg::THR_W-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= tmf_pkg::RST_LINE_WIDTH;
      frame_height_q <= tmf_pkg::RST_FRAME_HEIGHT;
      thresh_q       <= tmf_pkg::RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmf_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_wdata_i;
        tmf_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        tmf_pkg::REG_KEEP_THRESH:  thresh_q       <= cfg_wdata_i[tmf_pkg::THR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  logic [CNT_W-1:0] eff_w, w_m1;
  logic [RW-1:0]    eff_h, h_m1;

  always_comb begin
    if (line_width_q < tmf_pkg::CFG_W'(tmf_pkg::MIN_SIZE)) begin
      eff_w = CNT_W'(tmf_pkg::MIN_SIZE);
    end else if (32'(line_width_q) > 32'(MAX_LINE)) begin
      eff_w = CNT_W'(MAX_LINE);
    end else begin
      eff_w = CNT_W'(line_width_q);
    end
    if (frame_height_q < tmf_pkg::CFG_W'(tmf_pkg::MIN_SIZE)) begin
      eff_h = RW'(tmf_pkg::MIN_SIZE);
    end else if (32'(frame_height_q) > 32'(tmf_pkg::MAX_HEIGHT)) begin
      eff_h = RW'(tmf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = RW'(frame_height_q);
    end
    w_m1 = eff_w - CNT_W'(1);
    h_m1 = eff_h - RW'(1);
  end

  // ---------------------------------------------------------------- handshake
  logic        s1_free, s1_leave, s2_en, out_en, accept;
  tmf_pkg::op_e s1_op_q;
  logic        s1_emit_q;
  logic        s2_valid_q, out_valid_q;

  assign out_en   = !out_valid_q || !out_stall_i;
  assign s2_en    = !s2_valid_q || out_en;
  assign s1_free  = (s1_op_q == tmf_pkg::OP_NONE) || !s1_emit_q || s2_en;
  assign s1_leave = (s1_op_q != tmf_pkg::OP_NONE) && s1_free;
  assign accept   = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  // ---------------------------------------------------------------- stage 0: counters
  logic [CNT_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]    in_row_q, in_row_d;
  logic [ORW-1:0]   out_row_q, out_row_d;

  logic [CNT_W-1:0] ic_n, oc_n, ic_inc;
  logic [RW-1:0]    ir_n;
  logic [ORW-1:0]   or_n;
  logic             drain, last_out, emit, filt, use_lower;
  tmf_pkg::op_e     op;
  logic [AW-1:0]    rd_addr;

  always_comb begin
    // wrap a counter left at the line end by the previous beat
    ic_n = in_col_q;
    ir_n = in_row_q;
    if (in_col_q >= eff_w) begin
      ic_n = '0;
      ir_n = in_row_q + RW'(1);
    end
    oc_n = out_col_q;
    or_n = out_row_q;
    if (out_col_q >= eff_w) begin
      oc_n = '0;
      or_n = out_row_q + ORW'(1);
    end

    drain    = ir_n >= eff_h;
    last_out = (RW'(or_n) >= h_m1) && (oc_n >= w_m1);
    ic_inc   = ic_n + CNT_W'(1);

    in_col_d  = ic_n;
    in_row_d  = ir_n;
    out_col_d = oc_n;
    out_row_d = or_n;
    emit      = 1'b0;
    filt      = 1'b0;
    use_lower = 1'b0;
    op        = tmf_pkg::OP_NONE;

    if (drain) begin
      op        = tmf_pkg::OP_DRAIN;
      emit      = 1'b1;
      use_lower = RW'(or_n) >= h_m1;
    end else if (!flush_i) begin
      op   = tmf_pkg::OP_PIXEL;
      emit = ((ic_n >= CNT_W'(1)) && (ir_n >= RW'(1)))
          || ((ic_n == '0) && (ir_n >= RW'(2)));
      filt = (ic_n >= CNT_W'(2)) && (ir_n >= RW'(2));
      if (ic_inc >= eff_w) begin
        in_col_d = '0;
        in_row_d = ir_n + RW'(1);
      end else begin
        in_col_d = ic_inc;
      end
    end

    if (emit) begin
      if (last_out) begin
        // plane done: restart every counter
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        out_col_d = oc_n + CNT_W'(1);
      end
    end

    rd_addr = drain ? oc_n[AW-1:0] : ic_n[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // ---------------------------------------------------------------- stage 1: stores, window
  logic          s1_filt_q, s1_lower_q, s1_end_q;
  logic [PW-1:0] s1_pix_q;
  logic [AW-1:0] s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_op_q   <= tmf_pkg::OP_NONE;
      s1_emit_q <= 1'b0;
    end else if (s1_free) begin
      s1_op_q   <= accept ? op : tmf_pkg::OP_NONE;
      s1_emit_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_filt_q  <= filt;
      s1_lower_q <= use_lower;
      s1_end_q   <= last_out;
      s1_pix_q   <= pixel_in_i;
      s1_addr_q  <= ic_n[AW-1:0];
    end
  end

  logic [PW-1:0] upper_rd, lower_rd;
  logic          store_we;

  assign store_we = s1_leave && (s1_op_q == tmf_pkg::OP_PIXEL);

  // upper takes the sample the lower store held, lower takes the new sample
  tmf_line_ram #(.DEPTH(MAX_LINE), .AW(AW)) u_upper (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_addr_q),
    .wdata_i (lower_rd),
    .re_i    (s1_free),
    .raddr_i (rd_addr),
    .rdata_o (upper_rd)
  );

  tmf_line_ram #(.DEPTH(MAX_LINE), .AW(AW)) u_lower (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (s1_free),
    .raddr_i (rd_addr),
    .rdata_o (lower_rd)
  );

  // window: cell 0 holds the newer column, cell 1 the older one
  tmf_pkg::col_t new_col;
  tmf_pkg::col_t cell_in  [tmf_pkg::NUM_CELLS];
  tmf_pkg::col_t cell_out [tmf_pkg::NUM_CELLS];
  logic [SW-1:0] cell_sum [tmf_pkg::NUM_CELLS];

  assign new_col.top = upper_rd;
  assign new_col.mid = lower_rd;
  assign new_col.bot = s1_pix_q;

  for (genvar g = 0; g < tmf_pkg::NUM_CELLS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_in[g] = new_col;
    end else begin : g_link
      assign cell_in[g] = cell_out[g-1];
    end
    tmf_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (store_we),
      .col_i   (cell_in[g]),
      .col_o   (cell_out[g]),
      .sum_o   (cell_sum[g])
    );
  end

  logic [SW-1:0] sum_d;
  logic [PW-1:0] centre_d;
  logic          filt_d;

  always_comb begin
    sum_d = SW'(upper_rd) + SW'(lower_rd) + SW'(s1_pix_q);
    for (int k = 0; k < tmf_pkg::NUM_CELLS; k++) begin
      sum_d = sum_d + cell_sum[k];
    end
    filt_d   = 1'b0;
    centre_d = cell_out[0].mid;
    case (s1_op_q)
      tmf_pkg::OP_PIXEL: filt_d = s1_filt_q;
      tmf_pkg::OP_DRAIN: centre_d = s1_lower_q ? lower_rd : cell_out[0].mid;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- stage 2: mean, select
  logic [SW-1:0] s2_sum_q;
  logic [PW-1:0] s2_centre_q;
  logic          s2_filt_q, s2_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_leave && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_leave && s1_emit_q) begin
      s2_sum_q    <= sum_d;
      s2_centre_q <= centre_d;
      s2_filt_q   <= filt_d;
      s2_end_q    <= s1_end_q;
    end
  end

  logic [tmf_pkg::PROD_W-1:0] prod;
  logic [PW-1:0]              mean, diff, result;

  always_comb begin
    prod = tmf_pkg::PROD_W'(s2_sum_q) * tmf_pkg::PROD_W'(tmf_pkg::RECIP_9);
    mean = prod[tmf_pkg::RECIP_SHIFT +: PW];
    diff = (mean > s2_centre_q) ? (mean - s2_centre_q) : (s2_centre_q - mean);
    // keep the centre when the mean strays too far, or on the border
    result = (!s2_filt_q || (diff > thresh_q)) ? s2_centre_q : mean;
  end

  // ---------------------------------------------------------------- output register
  logic [PW-1:0] out_pix_q;
  logic          out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_pix_q <= result;
      out_end_q <= s2_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign frame_end_o = out_end_q;

endmodule
